>>> rtl/hhe_pkg.sv
// Shared types, constants and helpers of the Host header extractor.
package hhe_pkg;

   localparam int HOST_BUFFER_BYTES = 256;
   localparam int STORE_DEPTH       = 256;
   localparam int ADDR_W            = $clog2(STORE_DEPTH);
   localparam int LEN_W             = 9;
   localparam int CMDQ_DEPTH        = 2;
   localparam int CMDQ_PTR_W        = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W        = $clog2(CMDQ_DEPTH + 1);

   localparam logic [LEN_W-1:0] LEN_SAT   = 9'd511;
   localparam logic [LEN_W-1:0] NONE_SEEN = 9'd511;

   localparam logic [2:0] ST_FOUND       = 3'd0;
   localparam logic [2:0] ST_HEADER_END  = 3'd1;
   localparam logic [2:0] ST_INPUT_ENDED = 3'd2;
   localparam logic [2:0] ST_EMPTY       = 3'd3;
   localparam logic [2:0] ST_TOO_LONG    = 3'd4;
   localparam logic [2:0] ST_NO_BRACKET  = 3'd5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5A;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_RBR   = 8'h5D;
   localparam logic [7:0] CASE_BIT = 8'h20;

   // One answer for the back end: a status, or a host slice of the store.
   typedef struct packed {
      logic             is_host;
      logic [2:0]       status;
      logic             start_one;
      logic [LEN_W-1:0] len;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   typedef struct packed {
      logic host_busy;
      logic hold;
   } front_stat_type;

   function automatic logic [7:0] prefix_char(input logic [1:0] col);
      logic [7:0] c;
      case (col)
         2'd0:    c = 8'h68; // h
         2'd1:    c = 8'h6F; // o
         2'd2:    c = 8'h73; // s
         default: c = 8'h74; // t
      endcase
      return c;
   endfunction

endpackage

>>> rtl/hhe_front.sv
// Byte parser: line framing, Host prefix match, value capture and answer decision.
module hhe_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_request_byte,
   input  logic                   req_end_of_request,
   output logic                   push,
   output hhe_pkg::cmd_type       cmd,
   input  logic                   q_full,
   input  logic                   host_done,
   output hhe_pkg::store_wr_type  wr,
   output hhe_pkg::front_stat_type stat
);

   localparam logic [1:0] PH_LINE_START = 2'd0;
   localparam logic [1:0] PH_SKIP_LINE  = 2'd1;
   localparam logic [1:0] PH_HOST_VALUE = 2'd2;
   localparam logic [1:0] PH_DONE       = 2'd3;

   logic [1:0]                phase_ff, phase_in;
   logic [2:0]                col_ff, col_in;
   logic                      cr_ff, cr_in;
   logic                      hold_ff, hold_in;
   logic [7:0]                hold_byte_ff, hold_byte_in;
   logic                      busy_ff, busy_in;
   logic [hhe_pkg::LEN_W-1:0] stored_ff, stored_in;
   logic [hhe_pkg::LEN_W-1:0] trimmed_ff, trimmed_in;
   logic [hhe_pkg::LEN_W-1:0] colon_ff, colon_in;
   logic [hhe_pkg::LEN_W-1:0] bracket_ff, bracket_in;
   logic [7:0]                first_ff, first_in;

   logic                      accept;
   logic                      do_content;
   logic [7:0]                cbyte;
   logic [7:0]                lb;
   logic                      blank;
   logic [hhe_pkg::LEN_W:0]   inc;
   logic [hhe_pkg::LEN_W-1:0] sat;
   logic [hhe_pkg::LEN_W-1:0] cut_len;

   assign req_ready = !hold_ff && !q_full && !(busy_ff && phase_ff == PH_HOST_VALUE);
   assign accept    = req_valid && req_ready;
   assign stat.host_busy = busy_ff;
   assign stat.hold      = hold_ff;

   assign lb    = (cbyte >= hhe_pkg::CH_UC_A && cbyte <= hhe_pkg::CH_UC_Z) ?
                  (cbyte | hhe_pkg::CASE_BIT) : cbyte;
   assign blank = (cbyte == hhe_pkg::CH_SP) || (cbyte == hhe_pkg::CH_TAB);
   assign inc   = {1'b0, stored_ff} + 10'd1;
   assign sat   = (inc > {1'b0, hhe_pkg::LEN_SAT}) ? hhe_pkg::LEN_SAT : inc[hhe_pkg::LEN_W-1:0];
   assign cut_len = (colon_ff < trimmed_ff) ? colon_ff : trimmed_ff;

   always_comb begin
      phase_in     = phase_ff;
      col_in       = col_ff;
      cr_in        = cr_ff;
      hold_in      = 1'b0;
      hold_byte_in = hold_byte_ff;
      busy_in      = busy_ff && !host_done;
      stored_in    = stored_ff;
      trimmed_in   = trimmed_ff;
      colon_in     = colon_ff;
      bracket_in   = bracket_ff;
      first_in     = first_ff;
      push         = 1'b0;
      cmd          = '0;
      wr           = '0;
      do_content   = 1'b0;
      cbyte        = req_request_byte;

      if (hold_ff) begin
         // byte that followed a lone CR, taken in the cycle after its transfer
         cbyte = hold_byte_ff;
         if (hold_byte_ff == hhe_pkg::CH_CR) begin
            cr_in = 1'b1;
         end else begin
            do_content = 1'b1;
         end
      end else if (accept) begin
         if (req_end_of_request) begin
            if (phase_ff != PH_DONE) begin
               push       = 1'b1;
               cmd.status = hhe_pkg::ST_INPUT_ENDED;
            end
            phase_in   = PH_LINE_START;
            col_in     = '0;
            cr_in      = 1'b0;
            stored_in  = '0;
            trimmed_in = '0;
            colon_in   = hhe_pkg::NONE_SEEN;
            bracket_in = hhe_pkg::NONE_SEEN;
         end else if (phase_ff == PH_DONE) begin
            phase_in = PH_DONE;
         end else if (req_request_byte == hhe_pkg::CH_NUL) begin
            push       = 1'b1;
            cmd.status = hhe_pkg::ST_INPUT_ENDED;
            phase_in   = PH_DONE;
         end else if (cr_ff && req_request_byte == hhe_pkg::CH_LF) begin
            cr_in = 1'b0;
            case (phase_ff)
               PH_SKIP_LINE: begin
                  phase_in = PH_LINE_START;
                  col_in   = '0;
               end
               PH_LINE_START: begin
                  if (col_ff == 3'd0) begin
                     push       = 1'b1;
                     cmd.status = hhe_pkg::ST_HEADER_END;
                     phase_in   = PH_DONE;
                  end else begin
                     col_in = '0;
                  end
               end
               PH_HOST_VALUE: begin
                  push     = 1'b1;
                  phase_in = PH_DONE;
                  if (trimmed_ff == '0) begin
                     cmd.status = hhe_pkg::ST_EMPTY;
                  end else if ({1'b0, trimmed_ff} >= 10'(hhe_pkg::HOST_BUFFER_BYTES) ||
                               {1'b0, trimmed_ff} > 10'(hhe_pkg::STORE_DEPTH)) begin
                     cmd.status = hhe_pkg::ST_TOO_LONG;
                  end else if (first_ff == hhe_pkg::CH_LBR) begin
                     if (bracket_ff >= trimmed_ff) begin
                        cmd.status = hhe_pkg::ST_NO_BRACKET;
                     end else if (bracket_ff <= 9'd1) begin
                        cmd.status = hhe_pkg::ST_EMPTY;
                     end else begin
                        cmd.is_host   = 1'b1;
                        cmd.status    = hhe_pkg::ST_FOUND;
                        cmd.start_one = 1'b1;
                        cmd.len       = bracket_ff - 9'd1;
                        busy_in       = 1'b1;
                     end
                  end else if (cut_len == '0) begin
                     cmd.status = hhe_pkg::ST_EMPTY;
                  end else begin
                     cmd.is_host = 1'b1;
                     cmd.status  = hhe_pkg::ST_FOUND;
                     cmd.len     = cut_len;
                     busy_in     = 1'b1;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end else if (cr_ff) begin
            // lone CR is content; the new byte waits in the hold register
            cr_in        = 1'b0;
            cbyte        = hhe_pkg::CH_CR;
            do_content   = 1'b1;
            hold_in      = 1'b1;
            hold_byte_in = req_request_byte;
         end else if (req_request_byte == hhe_pkg::CH_CR) begin
            cr_in = 1'b1;
         end else begin
            do_content = 1'b1;
         end
      end

      if (do_content) begin
         case (phase_ff)
            PH_LINE_START: begin
               if (col_ff < 3'd4) begin
                  if ((cbyte | hhe_pkg::CASE_BIT) == hhe_pkg::prefix_char(col_ff[1:0])) begin
                     col_in = col_ff + 3'd1;
                  end else begin
                     phase_in = PH_SKIP_LINE;
                  end
               end else if (cbyte == hhe_pkg::CH_COLON) begin
                  phase_in   = PH_HOST_VALUE;
                  stored_in  = '0;
                  trimmed_in = '0;
                  colon_in   = hhe_pkg::NONE_SEEN;
                  bracket_in = hhe_pkg::NONE_SEEN;
               end else begin
                  phase_in = PH_SKIP_LINE;
               end
            end
            PH_HOST_VALUE: begin
               if (!(stored_ff == '0 && blank)) begin
                  if (stored_ff < 9'(hhe_pkg::STORE_DEPTH)) begin
                     wr.en   = 1'b1;
                     wr.addr = stored_ff[hhe_pkg::ADDR_W-1:0];
                     wr.data = lb;
                     if (stored_ff == '0) begin
                        first_in = lb;
                     end
                     if (lb == hhe_pkg::CH_COLON && colon_ff == hhe_pkg::NONE_SEEN) begin
                        colon_in = stored_ff;
                     end
                     if (lb == hhe_pkg::CH_RBR && bracket_ff == hhe_pkg::NONE_SEEN) begin
                        bracket_in = stored_ff;
                     end
                  end
                  if (!blank) begin
                     trimmed_in = sat;
                  end
                  stored_in = sat;
               end
            end
            default: begin
               phase_in = phase_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LINE_START;
         col_ff     <= '0;
         cr_ff      <= 1'b0;
         hold_ff    <= 1'b0;
         busy_ff    <= 1'b0;
         stored_ff  <= '0;
         trimmed_ff <= '0;
         colon_ff   <= hhe_pkg::NONE_SEEN;
         bracket_ff <= hhe_pkg::NONE_SEEN;
      end else begin
         phase_ff   <= phase_in;
         col_ff     <= col_in;
         cr_ff      <= cr_in;
         hold_ff    <= hold_in;
         busy_ff    <= busy_in;
         stored_ff  <= stored_in;
         trimmed_ff <= trimmed_in;
         colon_ff   <= colon_in;
         bracket_ff <= bracket_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      first_ff     <= first_in;
   end

endmodule

>>> rtl/hhe_cmd_queue.sv
// Short command queue between the parser and the result sequencer.
module hhe_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hhe_pkg::cmd_type push_cmd,
   input  logic             pop,
   output hhe_pkg::cmd_type head,
   output logic             not_empty,
   output logic             full
);

   hhe_pkg::cmd_type                 entry_ff [hhe_pkg::CMDQ_DEPTH];
   logic [hhe_pkg::CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [hhe_pkg::CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [hhe_pkg::CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                             do_push, do_pop;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == hhe_pkg::CMDQ_CNT_W'(hhe_pkg::CMDQ_DEPTH);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == hhe_pkg::CMDQ_PTR_W'(hhe_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == hhe_pkg::CMDQ_PTR_W'(hhe_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/hhe_back.sv
// Value store and result sequencer: turns commands into status or host chunk transfers.
module hhe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  hhe_pkg::cmd_type      q_head,
   output logic                  q_pop,
   input  hhe_pkg::store_wr_type wr,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [63:0]           rsp_host_chunk,
   output logic [3:0]            rsp_chunk_bytes,
   output logic                  rsp_last_chunk,
   output logic                  host_done
);

   localparam logic [1:0] B_IDLE   = 2'd0;
   localparam logic [1:0] B_FETCH  = 2'd1;
   localparam logic [1:0] B_GATHER = 2'd2;
   localparam logic [1:0] B_SEND   = 2'd3;

   logic [7:0]                 store_mem [hhe_pkg::STORE_DEPTH];
   logic [7:0]                 rdata_ff;
   logic                       rd_en;
   logic [hhe_pkg::ADDR_W-1:0] rd_addr;
   logic [hhe_pkg::LEN_W-1:0]  addr_sum;

   logic [1:0]                 state_ff, state_in;
   hhe_pkg::cmd_type           cmd_ff, cmd_in;
   logic [hhe_pkg::LEN_W-1:0]  pos_ff, pos_in;
   logic [hhe_pkg::LEN_W-1:0]  pos_next;
   logic [2:0]                 lane_ff, lane_in;
   logic [63:0]                chunk_ff, chunk_in;
   logic [3:0]                 bytes_ff, bytes_in;
   logic                       last_ff, last_in;
   logic [2:0]                 status_ff, status_in;

   assign rsp_valid       = state_ff == B_SEND;
   assign rsp_status      = status_ff;
   assign rsp_host_chunk  = chunk_ff;
   assign rsp_chunk_bytes = bytes_ff;
   assign rsp_last_chunk  = last_ff;

   assign pos_next = pos_ff + 9'd1;
   assign addr_sum = pos_ff + {{(hhe_pkg::LEN_W-1){1'b0}}, cmd_ff.start_one};
   assign rd_addr  = addr_sum[hhe_pkg::ADDR_W-1:0];

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      lane_in   = lane_ff;
      chunk_in  = chunk_ff;
      bytes_in  = bytes_ff;
      last_in   = last_ff;
      status_in = status_ff;
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      host_done = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               chunk_in = '0;
               if (q_head.is_host) begin
                  pos_in   = '0;
                  lane_in  = '0;
                  state_in = B_FETCH;
               end else begin
                  status_in = q_head.status;
                  bytes_in  = '0;
                  last_in   = 1'b1;
                  state_in  = B_SEND;
               end
            end
         end
         B_FETCH: begin
            rd_en    = 1'b1;
            state_in = B_GATHER;
         end
         B_GATHER: begin
            chunk_in[{lane_ff, 3'b000} +: 8] = rdata_ff;
            pos_in  = pos_next;
            lane_in = lane_ff + 3'd1;
            if (lane_ff == 3'd7 || pos_next == cmd_ff.len) begin
               status_in = hhe_pkg::ST_FOUND;
               bytes_in  = {1'b0, lane_ff} + 4'd1;
               last_in   = pos_next == cmd_ff.len;
               state_in  = B_SEND;
            end else begin
               state_in = B_FETCH;
            end
         end
         B_SEND: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  host_done = cmd_ff.is_host;
                  state_in  = B_IDLE;
               end else begin
                  chunk_in = '0;
                  lane_in  = '0;
                  state_in = B_FETCH;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      lane_ff   <= lane_in;
      chunk_ff  <= chunk_in;
      bytes_ff  <= bytes_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

endmodule

>>> rtl/http_host_header_extractor.sv
// Top level of the HTTP Host header extractor: parser, command queue and result sequencer.
// The parser takes one request byte per cycle while req_ready is high. A CR followed by
// anything other than LF makes it hold the next byte and take no new one meanwhile, because
// that CR and the next byte each go through the single store write port. While the previous
// host is still being sent, a byte that belongs to a new Host value waits until the sequencer
// has moved the last chunk. Each answer passes through a two-entry command queue to the
// sequencer, which reads the 256-byte value store one byte at a time in a fetch and a gather
// state: a host of L bytes comes out as ceil(L/8) transfers, a status answer as one transfer.
// The store needs no clearing after reset: only bytes of the current value are read.
module http_host_header_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_request_byte,
   input  logic        req_end_of_request,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_host_chunk,
   output logic [3:0]  rsp_chunk_bytes,
   output logic        rsp_last_chunk
);

   hhe_pkg::cmd_type        push_cmd;
   hhe_pkg::cmd_type        head_cmd;
   hhe_pkg::store_wr_type   store_wr;
   hhe_pkg::front_stat_type front_stat;
   logic                    push;
   logic                    pop;
   logic                    q_full;
   logic                    q_not_empty;
   logic                    host_done;

   hhe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_request_byte   (req_request_byte),
      .req_end_of_request (req_end_of_request),
      .push               (push),
      .cmd                (push_cmd),
      .q_full             (q_full),
      .host_done          (host_done),
      .wr                 (store_wr),
      .stat               (front_stat)
   );

   hhe_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   hhe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_head          (head_cmd),
      .q_pop           (pop),
      .wr              (store_wr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_host_chunk  (rsp_host_chunk),
      .rsp_chunk_bytes (rsp_chunk_bytes),
      .rsp_last_chunk  (rsp_last_chunk),
      .host_done       (host_done)
   );

   // the store is never written while a host is still being read out
   a_store_write_idle: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> !front_stat.host_busy)
      else $error("value store written while host readout pending");

   // a command is never pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command pushed into full queue");

   // a found chunk carries one to eight bytes, a status transfer none
   a_chunk_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == hhe_pkg::ST_FOUND) ?
                     (rsp_chunk_bytes != 4'd0 && rsp_chunk_bytes <= 4'd8) :
                     (rsp_chunk_bytes == 4'd0 && rsp_last_chunk)))
      else $error("bad chunk byte count");

   // a held byte always takes the cycle after its transfer, with no new transfer
   a_hold_follows: assert property (@(posedge clock) disable iff (reset)
      front_stat.hold |-> !req_ready && $past(req_valid && req_ready))
      else $error("held byte without a preceding transfer");

endmodule

>>> test/tb_top.sv
// Testbench for the HTTP Host header extractor: directed and random request heads.
`timescale 1ns / 1ps

module tb_top;
   import hhe_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam int unsigned DRAIN_CYCLES   = 600;
   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned RANDOM_BYTES   = 210;
   localparam int unsigned RANDOM_ANSWERS = 48;
   localparam logic [3:0]  BY_MODEL       = 4'hF;   // answer comes from the predictor
   localparam logic [31:0] HOST_WORD      = "host";

   typedef enum logic [1:0] {PH_LINE_START, PH_SKIP_LINE, PH_HOST_VALUE, PH_DONE} scan_phase_t;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] chunk;
      logic [3:0]  nbytes;
      logic        is_last;
   } host_result_t;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [7:0]  req_request_byte   = 8'h00;
   logic        req_end_of_request = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_host_chunk;
   logic [3:0]  rsp_chunk_bytes;
   logic        rsp_last_chunk;

   // predictor state
   logic [7:0]   host_bytes [STORE_DEPTH];
   scan_phase_t  scan_phase;
   int unsigned  prefix_len;
   logic         cr_waiting;
   int unsigned  kept_len;
   int unsigned  solid_len;
   int unsigned  colon_pos;
   int unsigned  close_pos;

   host_result_t step_answers[$];   // answers caused by the latest transfer
   host_result_t due_answers[$];    // answers still to come from the block, oldest first

   logic [7:0]   req_bytes[$];
   string        probe_text[$];
   logic [3:0]   probe_answer[$];
   logic [3:0]   typed_code = BY_MODEL;
   logic         typed_filed;

   logic         tx_burst   = 1'b0;
   logic         rx_burst   = 1'b0;
   logic         hold_ask   = 1'b0;
   int unsigned  mismatches = 0;
   int unsigned  cycle_count = 0;
   int unsigned  live_bytes = 0;
   int unsigned  due_total  = 0;
   int unsigned  requests   = 0;
   int unsigned  host_chunks = 0;
   int unsigned  status_answers = 0;

   http_host_header_extractor i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Cycle limit of %0d reached with %0d answers due", CYCLE_LIMIT,
                  due_answers.size());
         $display("tb_top failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_parse();
      scan_phase = PH_LINE_START;
      prefix_len = 0;
      cr_waiting = 1'b0;
      kept_len   = 0;
      solid_len  = 0;
      colon_pos  = NONE_SEEN;
      close_pos  = NONE_SEEN;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return b == CH_SP || b == CH_TAB;
   endfunction

   function automatic void give_status(input logic [2:0] code);
      host_result_t r;
      r = '{code, 64'd0, 4'd0, 1'b1};
      step_answers.push_back(r);
      scan_phase = PH_DONE;
   endfunction

   function automatic void give_host(input int unsigned start, input int unsigned len);
      int unsigned  pos;
      int unsigned  nb;
      int unsigned  i;
      host_result_t r;
      pos = 0;
      while (pos < len) begin
         nb = (len - pos > 8) ? 8 : len - pos;
         r  = '0;
         for (i = 0; i < nb; i++)
            r.chunk[8*i +: 8] = host_bytes[(start + pos + i) % STORE_DEPTH];
         pos += nb;
         r.status  = ST_FOUND;
         r.nbytes  = 4'(nb);
         r.is_last = (pos >= len);
         step_answers.push_back(r);
      end
      scan_phase = PH_DONE;
   endfunction

   function automatic void take_content(input logic [7:0] b);
      int unsigned idx;
      logic [7:0]  lb;
      idx = kept_len;
      lb  = (b >= CH_UC_A && b <= CH_UC_Z) ? b + CASE_BIT : b;
      case (scan_phase)
         PH_LINE_START: begin
            if (prefix_len < 4) begin
               if ((b | CASE_BIT) == HOST_WORD[8*(3-prefix_len) +: 8]) prefix_len++;
               else scan_phase = PH_SKIP_LINE;
            end else if (b == CH_COLON) begin
               scan_phase = PH_HOST_VALUE;
               kept_len   = 0;
               solid_len  = 0;
               colon_pos  = NONE_SEEN;
               close_pos  = NONE_SEEN;
            end else begin
               scan_phase = PH_SKIP_LINE;
            end
         end
         PH_HOST_VALUE: begin
            // leading blanks are dropped; bytes past the store only count
            if (!(idx == 0 && is_blank(b))) begin
               if (idx < STORE_DEPTH) begin
                  host_bytes[idx] = lb;
                  if (lb == CH_COLON && colon_pos == NONE_SEEN) colon_pos = idx;
                  if (lb == CH_RBR && close_pos == NONE_SEEN) close_pos = idx;
               end
               if (!is_blank(b)) solid_len = (idx + 1 > LEN_SAT) ? LEN_SAT : idx + 1;
               kept_len = (idx < LEN_SAT) ? idx + 1 : LEN_SAT;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void take_line_end();
      int unsigned len;
      len = solid_len;
      case (scan_phase)
         PH_SKIP_LINE: begin
            scan_phase = PH_LINE_START;
            prefix_len = 0;
         end
         PH_LINE_START: begin
            if (prefix_len == 0) give_status(ST_HEADER_END);
            else prefix_len = 0;
         end
         PH_HOST_VALUE: begin
            if (len == 0) give_status(ST_EMPTY);
            else if (len >= HOST_BUFFER_BYTES || len > STORE_DEPTH) give_status(ST_TOO_LONG);
            else if (host_bytes[0] == CH_LBR) begin
               if (close_pos >= len) give_status(ST_NO_BRACKET);
               else if (close_pos <= 1) give_status(ST_EMPTY);
               else give_host(1, close_pos - 1);
            end else begin
               if (colon_pos < len) len = colon_pos;
               if (len == 0) give_status(ST_EMPTY);
               else give_host(0, len);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void parse_host_byte(input logic [7:0] b, input logic eor);
      if (eor) begin
         if (scan_phase != PH_DONE) give_status(ST_INPUT_ENDED);
         clear_parse();
      end else if (scan_phase != PH_DONE) begin
         if (b == CH_NUL) give_status(ST_INPUT_ENDED);
         else if (cr_waiting && b == CH_LF) begin
            cr_waiting = 1'b0;
            take_line_end();
         end else begin
            // a CR not followed by LF is plain content
            if (cr_waiting) begin
               cr_waiting = 1'b0;
               take_content(CH_CR);
            end
            if (b == CH_CR) cr_waiting = 1'b1;
            else take_content(b);
         end
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic add_probe(input string text, input logic [3:0] answer);
      probe_text.push_back(text);
      probe_answer.push_back(answer);
   endtask

   // '~' is CR LF, '#' a run of HOST_BUFFER_BYTES letters, '%' one letter fewer, '@' a NUL
   task automatic append_text(input string text);
      int i;
      int k;
      for (i = 0; i < text.len(); i++) begin
         case (text[i])
            "~": begin
               req_bytes.push_back(CH_CR);
               req_bytes.push_back(CH_LF);
            end
            "#", "%": begin
               for (k = 0; k < HOST_BUFFER_BYTES - (text[i] == "%"); k++)
                  req_bytes.push_back(8'(((k % 3 == 0) ? "A" : "a") + k % 26));
            end
            "@":     req_bytes.push_back(CH_NUL);
            default: req_bytes.push_back(text[i]);
         endcase
      end
   endtask

   function automatic logic [7:0] value_byte();
      logic [7:0] c;
      case ($urandom_range(0, 12))
         0, 1, 2: c = 8'("a" + $urandom_range(0, 25));
         3:       c = 8'("A" + $urandom_range(0, 25));
         4:       c = 8'("0" + $urandom_range(0, 9));
         5:       c = ".";
         6:       c = "-";
         7:       c = CH_COLON;
         8:       c = CH_LBR;
         9:       c = CH_RBR;
         10:      c = CH_SP;
         11:      c = CH_TAB;
         default: c = CH_CR;
      endcase
      return c;
   endfunction

   task automatic build_random_request();
      int         i;
      int         n;
      logic       bracketed;
      req_bytes.delete();
      if ($urandom_range(0, 4) == 0) begin
         // noise: any byte at all, NUL and stray CR/LF included
         n = $urandom_range(1, 12);
         repeat (n) req_bytes.push_back(8'($urandom));
         return;
      end
      if ($urandom_range(0, 1)) append_text("GET /x HTTP/1.1~");
      repeat ($urandom_range(0, 2)) begin
         // other headers, often near misses of the host prefix
         n = $urandom_range(1, 5);
         for (i = 0; i < n; i++)
            req_bytes.push_back((i < 4) ?
               HOST_WORD[8*(3-i) +: 8] ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00) :
               8'("a" + $urandom_range(0, 25)));
         req_bytes.push_back(CH_COLON);
         repeat ($urandom_range(0, 4)) req_bytes.push_back(value_byte());
         append_text("~");
      end
      for (i = 0; i < 4; i++)
         req_bytes.push_back(HOST_WORD[8*(3-i) +: 8] ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00));
      req_bytes.push_back(($urandom_range(0, 7) == 0) ? value_byte() : CH_COLON);
      repeat ($urandom_range(0, 2)) req_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
      bracketed = ($urandom_range(0, 3) == 0);
      if (bracketed) req_bytes.push_back(CH_LBR);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 70) : $urandom_range(0, 14);
      repeat (n) req_bytes.push_back(value_byte());
      if (bracketed && $urandom_range(0, 3) != 0) append_text("]:80");
      repeat ($urandom_range(0, 2)) req_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
      append_text("~");
      if ($urandom_range(0, 1)) append_text("Accept: */*~");
      if ($urandom_range(0, 1)) append_text("~");
      // broken head: cut off somewhere
      if ($urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, req_bytes.size());
         repeat (n) void'(req_bytes.pop_back());
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eor);
      int           gap;
      host_result_t typed_res;
      gap = tx_burst ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_request_byte   <= b;
      req_end_of_request <= eor;
      do @(posedge clock); while (!req_ready);
      if (!eor && scan_phase != PH_DONE) live_bytes++;
      parse_host_byte(b, eor);
      foreach (step_answers[i]) begin
         if (typed_code == BY_MODEL) begin
            due_answers.push_back(step_answers[i]);
            due_total++;
         end else if (!typed_filed) begin
            typed_res = '{typed_code[2:0], 64'd0, 4'd0, 1'b1};
            due_answers.push_back(typed_res);
            due_total++;
            typed_filed = 1'b1;
         end
      end
      step_answers.delete();
   endtask

   task automatic send_request();
      requests++;
      tx_burst    = ($urandom_range(0, 3) == 0);
      typed_filed = 1'b0;
      foreach (req_bytes[i]) send_byte(req_bytes[i], 1'b0);
      send_byte(8'($urandom), 1'b1);
   endtask

   task automatic hold_until_answered();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_answers.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned bytes_mark;
      int unsigned due_mark;
      clear_parse();

      add_probe("~",                                ST_HEADER_END);
      add_probe("GET / HTTP/1.1~Host: Example.COM~~", BY_MODEL);
      add_probe("host:a~",                          BY_MODEL);
      add_probe("HOST:\t [::1]:8080 \t~",           BY_MODEL);
      add_probe("Host:[]~",                         ST_EMPTY);
      add_probe("Host: [abc~",                      ST_NO_BRACKET);
      add_probe("Host: :80~",                       ST_EMPTY);
      add_probe("Host: \t ~",                       ST_EMPTY);
      add_probe("Host :x~~",                        ST_HEADER_END);
      add_probe("Host: #~",                         ST_TOO_LONG);
      add_probe("Host: %~",                         BY_MODEL);
      add_probe("Host: a~",                         BY_MODEL);
      add_probe("Host: ###~",                       ST_TOO_LONG);
      add_probe("Host: ab@xyz~",                    ST_INPUT_ENDED);
      add_probe("",                                 ST_INPUT_ENDED);
      add_probe("X-A: 1~hOsT:w\015x~",              BY_MODEL);
      add_probe("Hostx: a~host;b~Host: c~",         BY_MODEL);
      add_probe("Host: a~Host: b~junk",             BY_MODEL);
      add_probe("ho~st: z~~",                       ST_HEADER_END);
      add_probe("Host: a\015~",                     BY_MODEL);
      add_probe("Host: x]y:z~",                     BY_MODEL);
      add_probe("Host: [a]b~",                      BY_MODEL);

      wait (!reset);
      foreach (probe_text[p]) begin
         typed_code = probe_answer[p];
         req_bytes.delete();
         append_text(probe_text[p]);
         // long rows: let the receiver stall hard while the sender keeps going
         if (req_bytes.size() > HOST_BUFFER_BYTES) hold_ask = 1'b1;
         send_request();
      end
      typed_code = BY_MODEL;
      hold_until_answered();

      bytes_mark = live_bytes;
      due_mark   = due_total;
      while (live_bytes - bytes_mark < RANDOM_BYTES || due_total - due_mark < RANDOM_ANSWERS) begin
         if ($urandom_range(0, 19) == 0) hold_ask = 1'b1;
         if ($urandom_range(0, 9) == 0) hold_until_answered();
         build_random_request();
         send_request();
      end

      hold_until_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests with %0d parsed bytes; checked %0d host chunks, %0d status answers",
               requests, live_bytes, host_chunks, status_answers);
      $display("Covered bracketed, port-cut, full-length and over-length hosts, bare CR content, "
               , "NUL ends and receiver hold-offs of %0d cycles", LONG_HOLD);
      if (mismatches == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // ---------------------------------------------------------------- result side

   initial begin
      int stall;
      wait (!reset);
      forever begin
         if (hold_ask) begin
            hold_ask = 1'b0;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end
         stall = rx_burst ? 0 : $urandom_range(0, 4);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      end
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      host_result_t got;
      host_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_host_chunk, rsp_chunk_bytes, rsp_last_chunk};
         if (got.nbytes != 0) host_chunks++;
         else status_answers++;
         if (due_answers.size() == 0) begin
            report_mismatch($sformatf("transfer with nothing due: status %0d chunk %h bytes %0d",
                                      got.status, got.chunk, got.nbytes));
         end else begin
            want = due_answers.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.chunk !== want.chunk)
               report_mismatch($sformatf("host chunk %h, want %h", got.chunk, want.chunk));
            if (got.nbytes !== want.nbytes)
               report_mismatch($sformatf("chunk bytes %0d, want %0d", got.nbytes, want.nbytes));
            if (got.is_last !== want.is_last)
               report_mismatch($sformatf("last chunk %b, want %b", got.is_last, want.is_last));
         end
      end
   end

endmodule
